// ===== rtl/arpc_pkg.sv =====
// Package for the ARP cache with round-robin replacement.
// Holds table sizing, codes, item structs and the memory control struct.
// No dependencies.
package arpc_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   localparam int IP_W  = 32;
   localparam int MAC_W = 48;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [IP_W-1:0]  IP_ONES  = '1;
   localparam logic [MAC_W-1:0] MAC_ONES = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NETWORK_MASK    = 1'b0,
      CSR_NETWORK_ADDRESS = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_ADD    = 1'b0,
      CMD_SEARCH = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_MISS     = 3'd0,
      ST_HIT      = 3'd1,
      ST_BCAST    = 3'd2,
      ST_UPDATED  = 3'd3,
      ST_INSERTED = 3'd4,
      ST_IGNORED  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic             command;
      logic [IP_W-1:0]  ip_address;
      logic [MAC_W-1:0] mac_address;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [MAC_W-1:0] mac_out;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             wr_ip;
      logic             wr_mac;
      logic [IDX_W-1:0] wr_addr;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } mem_ctl_type;

endpackage

// ===== rtl/arpc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module arpc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/arpc_ctrl.sv =====
// Sequencer for the ARP cache: classifies items, scans the table memories,
// updates or inserts, and keeps entry valid bits and the victim pointer. Uses arpc_pkg.
module arpc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  arpc_pkg::req_type             req_data,
   input  logic [arpc_pkg::IP_W-1:0]     net_mask,
   input  logic [arpc_pkg::IP_W-1:0]     net_addr,
   output arpc_pkg::mem_ctl_type         mem_ctl,
   input  logic [arpc_pkg::IP_W-1:0]     rd_ip,
   input  logic [arpc_pkg::MAC_W-1:0]    rd_mac,
   output logic                          res_valid,
   input  logic                          res_stall,
   output arpc_pkg::rsp_type             res_data
);

   arpc_pkg::state_type state_ff, state_in;
   logic                              cmd_ff, cmd_in;
   logic [arpc_pkg::IP_W-1:0]         ip_ff, ip_in;
   logic [arpc_pkg::MAC_W-1:0]        mac_ff, mac_in;
   logic [arpc_pkg::IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [arpc_pkg::IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   logic                              chk_vld_ff, chk_vld_in;
   logic [arpc_pkg::TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [arpc_pkg::IDX_W-1:0]        victim_ff, victim_in;
   arpc_pkg::rsp_type                 res_ff, res_in;

   logic [arpc_pkg::IP_W-1:0]  bcast;
   logic [arpc_pkg::IP_W-1:0]  ent_ip;
   logic [arpc_pkg::MAC_W-1:0] ent_mac;
   logic                       is_special;

   assign bcast = ~net_mask | net_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= arpc_pkg::S_IDLE;
         chk_vld_ff <= 1'b0;
         valid_ff   <= '0;
         victim_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         valid_ff   <= valid_in;
         victim_ff  <= victim_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ip_ff       <= ip_in;
      mac_ff      <= mac_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      res_ff      <= res_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      ip_in       = ip_ff;
      mac_in      = mac_ff;
      scan_idx_in = scan_idx_ff;
      chk_idx_in  = chk_idx_ff;
      chk_vld_in  = 1'b0;
      valid_in    = valid_ff;
      victim_in   = victim_ff;
      res_in      = res_ff;
      req_stall   = 1'b1;
      res_valid   = 1'b0;
      is_special  = 1'b0;

      mem_ctl         = '0;
      mem_ctl.rd_addr = scan_idx_ff;
      mem_ctl.ip      = ip_ff;
      mem_ctl.mac     = mac_ff;

      // cleared entries read as zero
      ent_ip  = valid_ff[chk_idx_ff] ? rd_ip  : '0;
      ent_mac = valid_ff[chk_idx_ff] ? rd_mac : '0;

      case (state_ff)
         arpc_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in      = req_data.command;
               ip_in       = req_data.ip_address;
               mac_in      = req_data.mac_address;
               scan_idx_in = '0;
               is_special  = (req_data.ip_address == arpc_pkg::IP_ONES) ||
                             (req_data.ip_address == bcast);
               if (req_data.command == arpc_pkg::CMD_ADD) begin
                  if (is_special || (req_data.ip_address == '0)) begin
                     res_in.status  = arpc_pkg::ST_IGNORED;
                     res_in.mac_out = '0;
                     state_in       = arpc_pkg::S_RESP;
                  end else begin
                     state_in = arpc_pkg::S_SCAN;
                  end
               end else begin
                  if (is_special) begin
                     res_in.status  = arpc_pkg::ST_BCAST;
                     res_in.mac_out = arpc_pkg::MAC_ONES;
                     state_in       = arpc_pkg::S_RESP;
                  end else begin
                     state_in = arpc_pkg::S_SCAN;
                  end
               end
            end
         end

         arpc_pkg::S_SCAN: begin
            chk_vld_in  = 1'b1;
            chk_idx_in  = scan_idx_ff;
            scan_idx_in = (scan_idx_ff == arpc_pkg::LAST_IDX) ? '0 : scan_idx_ff + 1'b1;
            if (chk_vld_ff) begin
               if (ent_ip == ip_ff) begin
                  chk_vld_in = 1'b0;
                  state_in   = arpc_pkg::S_RESP;
                  if (cmd_ff == arpc_pkg::CMD_SEARCH) begin
                     res_in.status  = arpc_pkg::ST_HIT;
                     res_in.mac_out = ent_mac;
                  end else begin
                     mem_ctl.wr_mac  = 1'b1;
                     mem_ctl.wr_addr = chk_idx_ff;
                     res_in.status   = arpc_pkg::ST_UPDATED;
                     res_in.mac_out  = '0;
                  end
               end else if (chk_idx_ff == arpc_pkg::LAST_IDX) begin
                  chk_vld_in     = 1'b0;
                  state_in       = arpc_pkg::S_RESP;
                  res_in.mac_out = '0;
                  if (cmd_ff == arpc_pkg::CMD_SEARCH) begin
                     res_in.status = arpc_pkg::ST_MISS;
                  end else begin
                     mem_ctl.wr_ip       = 1'b1;
                     mem_ctl.wr_mac      = 1'b1;
                     mem_ctl.wr_addr     = victim_ff;
                     valid_in[victim_ff] = 1'b1;
                     victim_in = (victim_ff == arpc_pkg::LAST_IDX) ? '0 : victim_ff + 1'b1;
                     res_in.status = arpc_pkg::ST_INSERTED;
                  end
               end
            end
         end

         arpc_pkg::S_RESP: begin
            res_valid = 1'b1;
            if (!res_stall) begin
               state_in = arpc_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = arpc_pkg::S_IDLE;
         end
      endcase
   end

   assign res_data = res_ff;

endmodule

// ===== rtl/arp_cache_round_robin.sv =====
// Top level of the ARP cache: configuration registers, the two table memories,
// the sequencer and the result register. Uses arpc_pkg, arpc_ram, arpc_ctrl.
//
//   port group   dir   handshake            payload
//   req_*        in    req_valid/req_stall  req_data   (arpc_pkg::req_type)
//   rsp_*        out   rsp_valid/rsp_stall  rsp_data   (arpc_pkg::rsp_type)
//   csr_*        in    csr_write_enable     csr_index, csr_write_data
//
// Adds and searches needing the table scan it one entry a cycle through the
// synchronous memories; ignored adds and broadcast searches skip the scan.
// Reset clears configuration, entry valid bits and the victim pointer at once.
// A result held by rsp_stall holds the sequencer until the result register frees.
module arp_cache_round_robin (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  arpc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output arpc_pkg::rsp_type                rsp_data,
   input  logic                             csr_write_enable,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic [arpc_pkg::IP_W-1:0]  net_mask_ff, net_mask_in;
   logic [arpc_pkg::IP_W-1:0]  net_addr_ff, net_addr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   arpc_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   arpc_pkg::mem_ctl_type      mem_ctl;
   logic [arpc_pkg::IP_W-1:0]  rd_ip;
   logic [arpc_pkg::MAC_W-1:0] rd_mac;
   logic                       res_valid;
   logic                       res_stall;
   arpc_pkg::rsp_type          res_data;

   always_comb begin
      net_mask_in = net_mask_ff;
      net_addr_in = net_addr_ff;
      if (csr_write_enable) begin
         case (arpc_pkg::csr_index_type'(csr_index))
            arpc_pkg::CSR_NETWORK_MASK:    net_mask_in = csr_write_data;
            arpc_pkg::CSR_NETWORK_ADDRESS: net_addr_in = csr_write_data;
            default: ;
         endcase
      end
   end

   assign res_stall = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (!res_stall) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         net_mask_ff  <= '0;
         net_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         net_mask_ff  <= net_mask_in;
         net_addr_ff  <= net_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   arpc_ram #(
      .WIDTH (arpc_pkg::IP_W),
      .DEPTH (arpc_pkg::TABLE_ENTRIES)
   ) u_ip_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_ip),
      .wr_addr (mem_ctl.wr_addr),
      .wr_data (mem_ctl.ip),
      .rd_addr (mem_ctl.rd_addr),
      .rd_data (rd_ip)
   );

   arpc_ram #(
      .WIDTH (arpc_pkg::MAC_W),
      .DEPTH (arpc_pkg::TABLE_ENTRIES)
   ) u_mac_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_mac),
      .wr_addr (mem_ctl.wr_addr),
      .wr_data (mem_ctl.mac),
      .rd_addr (mem_ctl.rd_addr),
      .rd_data (rd_mac)
   );

   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .net_mask  (net_mask_ff),
      .net_addr  (net_addr_ff),
      .mem_ctl   (mem_ctl),
      .rd_ip     (rd_ip),
      .rd_mac    (rd_mac),
      .res_valid (res_valid),
      .res_stall (res_stall),
      .res_data  (res_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/arpc_checker.sv =====
// Port-level checks for the ARP cache, bound to arp_cache_round_robin.
// Uses arpc_pkg.
module arpc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input arpc_pkg::rsp_type rsp_data
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= arpc_pkg::ST_IGNORED))
      else $error("status code out of range");

   a_mac_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == arpc_pkg::ST_MISS ||
                    rsp_data.status == arpc_pkg::ST_UPDATED ||
                    rsp_data.status == arpc_pkg::ST_INSERTED ||
                    rsp_data.status == arpc_pkg::ST_IGNORED)
      |-> rsp_data.mac_out == '0)
      else $error("mac_out not zero on miss or add");

   a_bcast_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == arpc_pkg::ST_BCAST
      |-> rsp_data.mac_out == arpc_pkg::MAC_ONES)
      else $error("broadcast result without all-ones MAC");

   // the sequencer takes nothing while a table item is in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous item in progress");

endmodule

bind arp_cache_round_robin arpc_checker u_arpc_checker (.*);

// ===== test/arp_cache_round_robin_tb.sv =====
// Self-checking testbench for arp_cache_round_robin: directed and random adds and searches,
// with random handshake gaps, a long result hold-off and several subnet settings.
// Depends on arpc_pkg and the arp_cache_round_robin RTL.
module arp_cache_round_robin_tb;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_ITEMS = 213;

   // Mirror of the table, the victim pointer and the subnet registers;
   // queues the expected result of each accepted item.
   class arp_ledger;
      logic [arpc_pkg::IP_W-1:0]  net_mask = '0;
      logic [arpc_pkg::IP_W-1:0]  net_base = '0;
      logic [arpc_pkg::IP_W-1:0]  ip_tab [arpc_pkg::TABLE_ENTRIES];
      logic [arpc_pkg::MAC_W-1:0] mac_tab [arpc_pkg::TABLE_ENTRIES];
      logic [arpc_pkg::IDX_W-1:0] victim = '0;
      arpc_pkg::rsp_type          expected_q [$];
      int unsigned                errors = 0;
      int unsigned                checked = 0;
      int unsigned                status_tally [8];

      function new();
         for (int i = 0; i < arpc_pkg::TABLE_ENTRIES; i++) begin
            ip_tab[i] = '0;
            mac_tab[i] = '0;
         end
         for (int i = 0; i < 8; i++) status_tally[i] = 0;
      endfunction

      function logic [arpc_pkg::IP_W-1:0] subnet_broadcast();
         return ~net_mask | net_base;
      endfunction

      function void set_register(arpc_pkg::csr_index_type idx,
                                 logic [arpc_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            arpc_pkg::CSR_NETWORK_MASK:    net_mask = value;
            arpc_pkg::CSR_NETWORK_ADDRESS: net_base = value;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(arpc_pkg::req_type item);
         logic [arpc_pkg::IP_W-1:0] bcast;
         arpc_pkg::rsp_type         want;
         int                        slot;
         bcast = subnet_broadcast();
         want = '0;
         slot = -1;
         for (int i = arpc_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
            if (ip_tab[i] == item.ip_address) slot = i;
         if (item.command == arpc_pkg::CMD_ADD) begin
            if (item.ip_address == '0 || item.ip_address == arpc_pkg::IP_ONES ||
                item.ip_address == bcast) begin
               want.status = arpc_pkg::ST_IGNORED;
            end else if (slot >= 0) begin
               mac_tab[slot] = item.mac_address;
               want.status = arpc_pkg::ST_UPDATED;
            end else begin
               ip_tab[victim] = item.ip_address;
               mac_tab[victim] = item.mac_address;
               victim = (victim == arpc_pkg::LAST_IDX) ? '0 : victim + 1'b1;
               want.status = arpc_pkg::ST_INSERTED;
            end
         end else begin
            if (item.ip_address == arpc_pkg::IP_ONES || item.ip_address == bcast) begin
               want.status = arpc_pkg::ST_BCAST;
               want.mac_out = arpc_pkg::MAC_ONES;
            end else if (slot >= 0) begin
               want.status = arpc_pkg::ST_HIT;
               want.mac_out = mac_tab[slot];
            end else begin
               want.status = arpc_pkg::ST_MISS;
            end
         end
         status_tally[want.status]++;
         expected_q.push_back(want);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 100) $display("MISMATCH @%0t: %s", $time, what);
      endtask

      task check_response(arpc_pkg::rsp_type got);
         arpc_pkg::rsp_type want;
         checked++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result status=%0d mac=%h",
                                      got.status, got.mac_out));
         end else begin
            want = expected_q.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, want %0d",
                                         checked, got.status, want.status));
            if (got.mac_out !== want.mac_out)
               report_mismatch($sformatf("result %0d mac %h, want %h",
                                         checked, got.mac_out, want.mac_out));
         end
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   arpc_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   arpc_pkg::rsp_type               rsp_data;
   logic                            csr_write_enable = 1'b0;
   logic [arpc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [arpc_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   arp_ledger                  ledger = new();
   int unsigned                sent_count = 0;
   int unsigned                settings_count = 0;
   int unsigned                cycle_count = 0;
   logic [arpc_pkg::IP_W-1:0]  addr_pool [24];

   arp_cache_round_robin DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, ledger.pending());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: random stalls, a quiet stretch, and one long hold-off.
   // Handshake values are sampled at the falling edge, ahead of the accepting edge.
   initial begin : result_side
      int unsigned       hold_left;
      bit                held;
      bit                take;
      arpc_pkg::rsp_type got;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         take = !reset && rsp_valid === 1'b1 && !rsp_stall;
         got = rsp_data;
         @(posedge clock);
         if (take) ledger.check_response(got);
         if (!held && ledger.checked >= 300) begin
            held = 1'b1;
            hold_left = 250;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (ledger.checked >= 700 && ledger.checked < 1000) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 12);
         end
      end
   end

   task automatic drive_item(input arpc_pkg::req_type item);
      logic stalled;
      while (!(sent_count >= 700 && sent_count < 1000) && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      ledger.note_request(item);
      sent_count++;
   endtask

   task automatic send(input arpc_pkg::command_type cmd,
                       input logic [arpc_pkg::IP_W-1:0] ip,
                       input logic [arpc_pkg::MAC_W-1:0] mac);
      arpc_pkg::req_type item;
      item.command = cmd;
      item.ip_address = ip;
      item.mac_address = mac;
      drive_item(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [arpc_pkg::CSR_DATA_W-1:0] mask_value,
                                 input logic [arpc_pkg::CSR_DATA_W-1:0] base_value);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= arpc_pkg::CSR_NETWORK_MASK;
      csr_write_data <= mask_value;
      @(posedge clock);
      csr_index <= arpc_pkg::CSR_NETWORK_ADDRESS;
      csr_write_data <= base_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ledger.set_register(arpc_pkg::CSR_NETWORK_MASK, mask_value);
      ledger.set_register(arpc_pkg::CSR_NETWORK_ADDRESS, base_value);
      settings_count++;
   endtask

   function automatic logic [arpc_pkg::MAC_W-1:0] random_mac();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 5) return '0;
      if (pick < 10) return arpc_pkg::MAC_ONES;
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic arpc_pkg::req_type random_item();
      arpc_pkg::req_type item;
      int unsigned       pick;
      item.command = ($urandom_range(99) < 50) ? arpc_pkg::CMD_SEARCH : arpc_pkg::CMD_ADD;
      item.mac_address = random_mac();
      pick = $urandom_range(99);
      if (pick < 72) begin
         item.ip_address = addr_pool[$urandom_range(23)];
      end else if (pick < 82) begin
         case ($urandom_range(2))
            0:       item.ip_address = '0;
            1:       item.ip_address = arpc_pkg::IP_ONES;
            default: item.ip_address = ledger.subnet_broadcast();
         endcase
      end else begin
         item.ip_address = $urandom;
      end
      return item;
   endfunction

   initial begin : stimulus
      logic [arpc_pkg::IP_W-1:0] mask_value;
      logic [arpc_pkg::IP_W-1:0] base_value;
      int unsigned               prefix;
      for (int i = 0; i < 24; i++) addr_pool[i] = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: the subnet broadcast is all-ones
      send(arpc_pkg::CMD_SEARCH, 32'h0000_0000,      48'h0);
      send(arpc_pkg::CMD_SEARCH, 32'h1234_5678,      arpc_pkg::MAC_ONES);
      send(arpc_pkg::CMD_ADD,    32'h0000_0000,      48'h0102_0304_0506);
      send(arpc_pkg::CMD_ADD,    arpc_pkg::IP_ONES,  48'h0a0b_0c0d_0e0f);
      send(arpc_pkg::CMD_SEARCH, arpc_pkg::IP_ONES,  48'h0);
      send(arpc_pkg::CMD_ADD,    32'h0000_0001,      48'h0);
      send(arpc_pkg::CMD_ADD,    32'hffff_fffe,      arpc_pkg::MAC_ONES);
      send(arpc_pkg::CMD_SEARCH, 32'h0000_0001,      arpc_pkg::MAC_ONES);
      send(arpc_pkg::CMD_SEARCH, 32'hffff_fffe,      48'h0);
      send(arpc_pkg::CMD_ADD,    32'h0000_0001,      48'ha5a5_5a5a_c3c3);
      send(arpc_pkg::CMD_SEARCH, 32'h0000_0001,      48'h0);
      send(arpc_pkg::CMD_SEARCH, 32'h0000_0000,      48'h0);

      apply_settings(32'hffff_ff00, 32'h0a00_0000);
      send(arpc_pkg::CMD_ADD,    32'h0a00_00ff, 48'h1111_2222_3333);
      send(arpc_pkg::CMD_SEARCH, 32'h0a00_00ff, 48'h0);
      send(arpc_pkg::CMD_ADD,    32'h0a00_0001, 48'h4444_5555_6666);
      send(arpc_pkg::CMD_SEARCH, 32'h0a00_0001, 48'h0);

      // a stored address becomes the subnet broadcast
      apply_settings(~32'h0a00_0001, 32'h0000_0000);
      send(arpc_pkg::CMD_SEARCH, 32'h0a00_0001, 48'h0);
      send(arpc_pkg::CMD_ADD,    32'h0a00_0001, 48'h7777_8888_9999);
      send(arpc_pkg::CMD_SEARCH, 32'hffff_fffe, 48'h0);
      send(arpc_pkg::CMD_SEARCH, 32'h0000_0000, 48'h0);

      for (int phase = 0; phase < 8; phase++) begin
         prefix = $urandom_range(31, 1);
         case (phase)
            0: begin mask_value = '1;            base_value = '1;            end
            1: begin mask_value = '1;            base_value = '0;            end
            2: begin mask_value = 32'hffff_ff00; base_value = {24'($urandom), 8'h00}; end
            3: begin mask_value = '0;            base_value = '1;            end
            4: begin
               mask_value = ~((32'h1 << prefix) - 1);
               base_value = 32'($urandom) & mask_value;
            end
            5: begin mask_value = $urandom;      base_value = $urandom;      end
            6: begin mask_value = '0;            base_value = '0;            end
            default: begin
               mask_value = 32'hffff_0000;
               base_value = 32'($urandom) & mask_value;
            end
         endcase
         apply_settings(mask_value, base_value);
         for (int i = 0; i < 8; i++) addr_pool[$urandom_range(23)] = $urandom;
         repeat (PHASE_ITEMS) drive_item(random_item());
      end

      drain();
      repeat (25) @(posedge clock);
      $display("%0d items under %0d subnet settings, %0d results checked, %0d mismatches",
               sent_count, settings_count, ledger.checked, ledger.errors);
      $display("miss %0d, hit %0d, broadcast %0d, updated %0d, inserted %0d, ignored %0d",
               ledger.status_tally[arpc_pkg::ST_MISS],
               ledger.status_tally[arpc_pkg::ST_HIT],
               ledger.status_tally[arpc_pkg::ST_BCAST],
               ledger.status_tally[arpc_pkg::ST_UPDATED],
               ledger.status_tally[arpc_pkg::ST_INSERTED],
               ledger.status_tally[arpc_pkg::ST_IGNORED]);
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_ctrl.sv
rtl/arp_cache_round_robin.sv
rtl/arpc_checker.sv
test/arp_cache_round_robin_tb.sv
